>>> hdl/rmd_pkg.sv
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared types, constants, round tables and microcode for the RIPEMD-160 hasher.
// ----------------------------------------------------------------------------
package rmd_pkg;

	localparam int WORD_W       = 32;
	localparam int BUF_DEPTH    = 16;
	localparam int BUF_AW       = $clog2(BUF_DEPTH);
	localparam int LEN_W        = 61;
	localparam int ROUNDS       = 80;
	localparam int RND_W        = $clog2(ROUNDS);
	localparam int DIGEST_WORDS = 5;
	localparam int IDX_W        = $clog2(DIGEST_WORDS);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [RND_W-1:0]  rnd_t;
	typedef logic [0:ROUNDS-1][3:0] rtab_t;

	localparam word_t IV [DIGEST_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	// message word select and rotate amounts, one nibble per round
	localparam rtab_t WL = 320'h0123456789abcdef_74d1a6f3c0952eb8_3ae49f812706db5c_19ba08c4d37fe562_40597c2ae138b6fd;
	localparam rtab_t WR = 320'h5e7092b4d6f81a3c_6b370d5aef8c4912_f5137e69b8c2a04d_86413bf05c2d97ae_cfa4158762de039b;
	localparam rtab_t SL = 320'hbefc5879bdef6798_768db97f7cf9b7dc_bd67e9dfe8d65c75_bcefef989e56865c_9f5b68dc5cdeb856;
	localparam rtab_t SR = 320'h899bdff5778beec6_9df7c89b77c76fdb_97fb866ecd5edd75_f58bee6e69c9c5f8_85c9c5e68d65fdbb;

	typedef enum logic [2:0] {
		OP_WAIT_IN,
		OP_PAD,
		OP_CINIT,
		OP_ROUND,
		OP_FINAL,
		OP_OUT
	} op_t;

	typedef enum logic [1:0] {
		JK_GOTO,
		JK_UNTIL,
		JK_DISPATCH
	} jump_t;

	typedef enum logic [1:0] {
		CD_NONE,
		CD_LAST_ROUND,
		CD_OUT_DONE
	} cond_t;

	typedef enum logic [2:0] {
		UP_IDLE,
		UP_PAD,
		UP_CINIT,
		UP_ROUND,
		UP_FINAL,
		UP_OUT
	} upc_t;

	typedef struct packed {
		op_t   op;
		jump_t jk;
		cond_t cond;
		upc_t  target;
	} ucw_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic full;
		logic pad;
		logic fin;
		logic last_round;
		logic out_done;
	} stat_t;

	function automatic ucw_t ucode(upc_t pc);
		ucw_t w;
		unique case (pc)
			UP_IDLE:  w = '{op: OP_WAIT_IN, jk: JK_DISPATCH, cond: CD_NONE,       target: UP_IDLE};
			UP_PAD:   w = '{op: OP_PAD,     jk: JK_DISPATCH, cond: CD_NONE,       target: UP_PAD};
			UP_CINIT: w = '{op: OP_CINIT,   jk: JK_GOTO,     cond: CD_NONE,       target: UP_ROUND};
			UP_ROUND: w = '{op: OP_ROUND,   jk: JK_UNTIL,    cond: CD_LAST_ROUND, target: UP_FINAL};
			UP_FINAL: w = '{op: OP_FINAL,   jk: JK_DISPATCH, cond: CD_NONE,       target: UP_FINAL};
			UP_OUT:   w = '{op: OP_OUT,     jk: JK_UNTIL,    cond: CD_OUT_DONE,   target: UP_IDLE};
			default:  w = '{op: OP_WAIT_IN, jk: JK_GOTO,     cond: CD_NONE,       target: UP_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic [3:0] tab_sel(rtab_t tab, rnd_t r);
		logic [3:0] v;
		v = 4'd0;
		if (r < RND_W'(ROUNDS)) v = tab[r];
		return v;
	endfunction

	function automatic word_t k_left(logic [2:0] g);
		word_t k;
		case (g)
			3'd1:    k = 32'h5A827999;
			3'd2:    k = 32'h6ED9EBA1;
			3'd3:    k = 32'h8F1BBCDC;
			3'd4:    k = 32'hA953FD4E;
			default: k = 32'h00000000;
		endcase
		return k;
	endfunction

	function automatic word_t k_right(logic [2:0] g);
		word_t k;
		case (g)
			3'd0:    k = 32'h50A28BE6;
			3'd1:    k = 32'h5C4DD124;
			3'd2:    k = 32'h6D703EF3;
			3'd3:    k = 32'h7A6D76E9;
			default: k = 32'h00000000;
		endcase
		return k;
	endfunction

	function automatic word_t bfun(logic [2:0] g, word_t x, word_t y, word_t z);
		word_t f;
		case (g)
			3'd0:    f = x ^ y ^ z;
			3'd1:    f = (x & y) | (~x & z);
			3'd2:    f = (x | ~y) ^ z;
			3'd3:    f = (x & z) | (y & ~z);
			default: f = x ^ (y | ~z);
		endcase
		return f;
	endfunction

	function automatic word_t rotl(word_t x, logic [4:0] s);
		logic [2*WORD_W-1:0] d;
		d = {x, x} << s;
		return d[2*WORD_W-1:WORD_W];
	endfunction

endpackage

>>> hdl/rmd_ram.sv
// ----------------------------------------------------------------------------
// rmd_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module rmd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> hdl/rmd_seq.sv
// ----------------------------------------------------------------------------
// rmd_seq
// Microcode sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
module rmd_seq import rmd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output op_t   op
);

	upc_t upc_q;
	upc_t upc_n;
	ucw_t ucw;
	logic cond_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UP_IDLE;
		end else begin
			upc_q <= upc_n;
		end
	end

	// control word of the current step
	always_comb begin
		ucw = ucode(upc_q);
		op  = ucw.op;
	end

	always_comb begin
		unique case (ucw.cond)
			CD_LAST_ROUND: cond_hit = stat.last_round;
			CD_OUT_DONE:   cond_hit = stat.out_done;
			default:       cond_hit = 1'b0;
		endcase
	end

	always_comb begin
		unique case (ucw.jk)
			JK_GOTO:  upc_n = ucw.target;
			JK_UNTIL: upc_n = cond_hit ? ucw.target : upc_q;
			JK_DISPATCH: begin
				if (stat.full) begin
					upc_n = UP_CINIT;
				end else if (stat.fin) begin
					upc_n = UP_OUT;
				end else if (stat.pad) begin
					upc_n = UP_PAD;
				end else begin
					upc_n = UP_IDLE;
				end
			end
			default: upc_n = UP_IDLE;
		endcase
	end

endmodule

>>> hdl/rmd_dp.sv
// ----------------------------------------------------------------------------
// rmd_dp
// Datapath: block buffer, length and pad control, shared double-line round
// unit, chaining value and digest output register.
// ----------------------------------------------------------------------------
module rmd_dp import rmd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  op_t         op,
	output stat_t       stat,
	input  logic        in_valid,
	output logic        in_stall,
	input  word_t       data_word,
	input  logic [2:0]  bytes_valid,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_stall,
	output word_t       digest_word,
	output logic [2:0]  word_index,
	output logic        digest_last
);

	localparam logic [BUF_AW-1:0] LO_POS   = BUF_AW'(BUF_DEPTH - 2);
	localparam logic [BUF_AW-1:0] LAST_POS = BUF_AW'(BUF_DEPTH - 1);

	word_t             chain_q [DIGEST_WORDS];
	word_t             lv_q [5];
	word_t             rv_q [5];
	logic [BUF_AW-1:0] filled_q;
	logic [LEN_W-1:0]  len_q;
	logic              pad_q;
	logic              need80_q;
	logic              lo_done_q;
	logic              final_q;
	rnd_t              cnt_q;
	logic              out_valid_q;
	word_t             out_word_q;
	logic [2:0]        out_idx_q;
	logic              out_last_q;

	logic              acc;
	logic              push;
	logic              full;
	logic              out_load;
	logic              out_done;
	logic [2:0]        nb_eff;
	word_t             in_word;
	word_t             pad_word;
	word_t             push_word;
	rnd_t              rd_round;
	word_t             w_l;
	word_t             w_r;
	logic [2:0]        g_l;
	logic [2:0]        g_r;
	word_t             t_l;
	word_t             t_r;
	logic [IDX_W-1:0]  oidx;

	assign acc      = in_valid && (op == OP_WAIT_IN);
	assign in_stall = (op != OP_WAIT_IN);

	// a short word counts only when it is the last one
	assign nb_eff = (!last_word || bytes_valid > 3'd4) ? 3'd4 : bytes_valid;

	always_comb begin
		case (nb_eff)
			3'd0:    in_word = 32'h00000080;
			3'd1:    in_word = {16'h0000, 8'h80, data_word[7:0]};
			3'd2:    in_word = {8'h00, 8'h80, data_word[15:0]};
			3'd3:    in_word = {8'h80, data_word[23:0]};
			default: in_word = data_word;
		endcase
	end

	// pad sequence: pad byte, zero fill, then bit length low and high words
	always_comb begin
		if (need80_q) begin
			pad_word = 32'h00000080;
		end else if (filled_q == LO_POS) begin
			pad_word = {len_q[28:0], 3'b000};
		end else if (filled_q == LAST_POS && lo_done_q) begin
			pad_word = len_q[LEN_W-1:29];
		end else begin
			pad_word = '0;
		end
	end

	assign push      = acc || (op == OP_PAD);
	assign push_word = (op == OP_PAD) ? pad_word : in_word;
	assign full      = push && (filled_q == LAST_POS);

	assign oidx     = cnt_q[IDX_W-1:0];
	assign out_load = (op == OP_OUT) && (!out_valid_q || !out_stall);
	assign out_done = out_load && (oidx == IDX_W'(DIGEST_WORDS - 1));

	always_comb begin
		stat.full       = full;
		stat.pad        = (pad_q || (acc && last_word)) && !out_done;
		stat.fin        = (final_q || ((op == OP_PAD) && !need80_q && lo_done_q
			&& filled_q == LAST_POS)) && !out_done;
		stat.last_round = (cnt_q == RND_W'(ROUNDS - 1));
		stat.out_done   = out_done;
	end

	// read addresses run one round ahead of the round unit
	assign rd_round = (op == OP_ROUND) ? cnt_q + RND_W'(1) : '0;

	rmd_ram #(
		.WIDTH (WORD_W),
		.DEPTH (BUF_DEPTH)
	) u_buf (
		.clk     (clk),
		.we      (push),
		.waddr   (filled_q),
		.wdata   (push_word),
		.raddr_a (tab_sel(WL, rd_round)),
		.raddr_b (tab_sel(WR, rd_round)),
		.rdata_a (w_l),
		.rdata_b (w_r)
	);

	assign g_l = cnt_q[RND_W-1:4];
	assign g_r = 3'd4 - g_l;
	assign t_l = rotl(lv_q[0] + bfun(g_l, lv_q[1], lv_q[2], lv_q[3]) + w_l + k_left(g_l),
		{1'b0, tab_sel(SL, cnt_q)}) + lv_q[4];
	assign t_r = rotl(rv_q[0] + bfun(g_r, rv_q[1], rv_q[2], rv_q[3]) + w_r + k_right(g_l),
		{1'b0, tab_sel(SR, cnt_q)}) + rv_q[4];

	always_ff @(posedge clk) begin
		if (op == OP_CINIT) begin
			for (int i = 0; i < 5; i++) begin
				lv_q[i] <= chain_q[i];
				rv_q[i] <= chain_q[i];
			end
		end else if (op == OP_ROUND) begin
			lv_q[0] <= lv_q[4];
			lv_q[4] <= lv_q[3];
			lv_q[3] <= rotl(lv_q[2], 5'd10);
			lv_q[2] <= lv_q[1];
			lv_q[1] <= t_l;
			rv_q[0] <= rv_q[4];
			rv_q[4] <= rv_q[3];
			rv_q[3] <= rotl(rv_q[2], 5'd10);
			rv_q[2] <= rv_q[1];
			rv_q[1] <= t_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				chain_q[i] <= IV[i];
			end
			filled_q  <= '0;
			len_q     <= '0;
			pad_q     <= 1'b0;
			need80_q  <= 1'b0;
			lo_done_q <= 1'b0;
			final_q   <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (push) begin
				filled_q <= filled_q + 1'b1;
			end
			if (acc) begin
				len_q <= len_q + LEN_W'(nb_eff);
				if (last_word) begin
					pad_q     <= 1'b1;
					need80_q  <= (nb_eff == 3'd4);
					lo_done_q <= 1'b0;
					final_q   <= 1'b0;
				end
			end
			if (op == OP_PAD) begin
				if (need80_q) begin
					need80_q <= 1'b0;
				end else if (filled_q == LO_POS) begin
					lo_done_q <= 1'b1;
				end else if (filled_q == LAST_POS && lo_done_q) begin
					final_q <= 1'b1;
				end
			end
			unique case (op)
				OP_CINIT: cnt_q <= '0;
				OP_ROUND: cnt_q <= cnt_q + RND_W'(1);
				OP_FINAL: begin
					cnt_q      <= '0;
					chain_q[0] <= chain_q[1] + lv_q[2] + rv_q[3];
					chain_q[1] <= chain_q[2] + lv_q[3] + rv_q[4];
					chain_q[2] <= chain_q[3] + lv_q[4] + rv_q[0];
					chain_q[3] <= chain_q[4] + lv_q[0] + rv_q[1];
					chain_q[4] <= chain_q[0] + lv_q[1] + rv_q[2];
				end
				OP_OUT: begin
					if (out_load && !out_done) begin
						cnt_q <= cnt_q + RND_W'(1);
					end
				end
				default: begin
				end
			endcase
			// digest handed off: back to the initial state
			if (out_done) begin
				for (int i = 0; i < DIGEST_WORDS; i++) begin
					chain_q[i] <= IV[i];
				end
				len_q     <= '0;
				pad_q     <= 1'b0;
				need80_q  <= 1'b0;
				lo_done_q <= 1'b0;
				final_q   <= 1'b0;
				cnt_q     <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q <= chain_q[oidx];
			out_idx_q  <= 3'(oidx);
			out_last_q <= (oidx == IDX_W'(DIGEST_WORDS - 1));
		end
	end

	assign out_valid   = out_valid_q;
	assign digest_word = out_word_q;
	assign word_index  = out_idx_q;
	assign digest_last = out_last_q;

	a_cinit_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_CINIT) |-> (filled_q == '0))
		else $error("compression started with a partly filled buffer");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_done |=> (len_q == '0 && !pad_q && chain_q[0] == IV[0]))
		else $error("state not restored after digest");

	a_lo_order: assert property (@(posedge clk) disable iff (!arst_n)
		lo_done_q |-> (pad_q && !need80_q))
		else $error("length word pushed before pad byte");

	a_final_order: assert property (@(posedge clk) disable iff (!arst_n)
		final_q |-> (lo_done_q && filled_q == '0))
		else $error("length high word without low word");

endmodule

>>> hdl/ripemd160_hash.sv
// ----------------------------------------------------------------------------
// ripemd160_hash
// RIPEMD-160 message hasher with a microcoded round sequencer.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one message word per accept, first
// byte in bits 7:0. bytes_valid gives the valid low bytes; only the word
// marked last_word may be short, and it may be empty.
// Output channel: out_valid/out_stall carry the five digest words h0..h4,
// word_index 0..4, digest_last on the fifth.
// Words are accepted only while the sequencer waits for input. Every full
// block then takes a load step, the 80 rounds of the shared double-line
// round unit (one round per cycle, message words read from the two-port
// block buffer one round ahead), and a feed-forward step. After the last
// word, the padding words are pushed one per cycle between compressions
// (one or two blocks); digest words follow one per cycle unless stalled.
// The output register lets the next message start while the final digest
// word still waits; a stalled receiver holds the word and pauses the digest.
// Reset loads the initial chaining value and clears length and pad state;
// the block then waits for a new message.
// ----------------------------------------------------------------------------
module ripemd160_hash import rmd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  bytes_valid,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        digest_last
);

	op_t   op;
	stat_t stat;

	rmd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.op     (op)
	);

	rmd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.stat        (stat),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_word   (data_word),
		.bytes_valid (bytes_valid),
		.last_word   (last_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_word (digest_word),
		.word_index  (word_index),
		.digest_last (digest_last)
	);

endmodule
